// ===== rtl/core/hmb_pkg.sv =====
// package for the heightmap mask blend block
// command codes, result kinds and default sizes; no dependencies
package hmb_pkg;
   localparam int MaxSideDefault     = 128;
   localparam int MaxDistanceDefault = 15;
   localparam int SampleBitsDefault  = 16;

   typedef enum logic [1:0] {
      CMD_LOAD = 2'd0,
      CMD_RUN  = 2'd1,
      CMD_READ = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic CSR_SIDE = 1'b0;
   localparam logic CSR_DIST = 1'b1;
endpackage

// ===== rtl/core/heightmap_mask_blend.sv =====
// heightmap mask blend top level: maps in two memories and the run sequencer
// depends on hmb_pkg and hmb_div
//
// channel | direction | ports
// req     | in        | req_valid/req_ready, command, address, base, mask
// rsp     | out       | rsp_valid/rsp_ready, result_kind, pixel_value
// csr     | in        | csr_write_enable, csr_index, csr_write_data
//
// a load is written as it is accepted; a read goes through state S_READ to a result word
// a run walks every pixel and, for a masked pixel, its window: a live target is
// read for its mask and its neighbors' masks and samples, then takes two serial
// divides of QW = 2*SAMPLE_BITS+8 bits; a skipped target and one with no usable
// neighbor skip the divides
// reset is synchronous; map contents stay undefined until loaded
// one word at a time; req_ready drops while a result word waits or a read or run is busy
module heightmap_mask_blend import hmb_pkg::*; #(
   parameter int MAX_SIDE     = MaxSideDefault,
   parameter int MAX_DISTANCE = MaxDistanceDefault,
   parameter int SAMPLE_BITS  = SampleBitsDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_command,
   input  logic [13:0]                   req_address,
   input  logic signed [SAMPLE_BITS-1:0] req_base_value,
   input  logic signed [SAMPLE_BITS-1:0] req_mask_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_result_kind,
   output logic signed [SAMPLE_BITS-1:0] rsp_pixel_value,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [7:0]                    csr_write_data
);
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = $clog2(DEPTH);
   // signed linear index wide enough for p + r*side + c
   localparam int IW    = AW + 3;
   localparam int DW    = $clog2(MAX_DISTANCE + 1) + 1;
   localparam int QW    = 2 * SAMPLE_BITS + 8;

   typedef enum logic [11:0] {
      S_IDLE  = 12'b000000000001,
      S_RDPIX = 12'b000000000010,
      S_PIX   = 12'b000000000100,
      S_TGT   = 12'b000000001000,
      S_TCHK  = 12'b000000010000,
      S_NB    = 12'b000000100000,
      S_NBACC = 12'b000001000000,
      S_AVG   = 12'b000010000000,
      S_MUL   = 12'b000100000000,
      S_QUO   = 12'b001000000000,
      S_NEXT  = 12'b010000000000,
      S_READ  = 12'b100000000000
   } state_type;

   // maps
   logic signed [SAMPLE_BITS-1:0] base_mem [DEPTH];
   logic signed [SAMPLE_BITS-1:0] mask_mem [DEPTH];
   logic [AW-1:0]                 rd_addr;
   logic signed [SAMPLE_BITS-1:0] base_rd_ff, mask_rd_ff;
   logic                          wr_en;
   logic [AW-1:0]                 wr_addr;
   logic signed [SAMPLE_BITS-1:0] wr_base, wr_mask;
   logic                          wr_mask_en;

   always_ff @(posedge clock) begin
      if (wr_en) base_mem[wr_addr] <= wr_base;
      if (wr_en && wr_mask_en) mask_mem[wr_addr] <= wr_mask;
      base_rd_ff <= base_mem[rd_addr];
      mask_rd_ff <= mask_mem[rd_addr];
   end

   // configuration
   logic [7:0] side_cfg_ff;
   logic [3:0] dist_cfg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         side_cfg_ff <= 8'd128;
         dist_cfg_ff <= 4'd2;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_SIDE) side_cfg_ff <= csr_write_data;
         else dist_cfg_ff <= csr_write_data[3:0];
      end
   end

   logic signed [IW-1:0] side, npix, dist_eff, span;
   always_comb begin
      side = (32'(side_cfg_ff) > MAX_SIDE) ? IW'(MAX_SIDE) : IW'(side_cfg_ff);
      dist_eff = (32'(dist_cfg_ff) > MAX_DISTANCE) ? IW'(MAX_DISTANCE)
                                                   : IW'(dist_cfg_ff);
      span = (dist_eff <<< 1) + IW'(1);
   end
   // pixel count follows the side register with no delay
   assign npix = side * side;

   // sequencer state
   state_type            state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 kind_ff, kind_in;
   logic signed [SAMPLE_BITS-1:0] pix_ff, pix_in;
   logic signed [IW-1:0] p_ff, p_in, t_ff, t_in, a_ff, a_in;
   logic signed [DW-1:0] r_ff, r_in, c_ff, c_in;
   logic [1:0]           i_ff, i_in, j_ff, j_in;  // 0..2 meaning -1..1
   logic signed [SAMPLE_BITS-1:0] m_ff, m_in;
   logic signed [SAMPLE_BITS+4-1:0] sum_ff, sum_in;
   logic [3:0]           cnt_ff, cnt_in;
   logic signed [QW-1:0] avg_ff, avg_in, prod_ff, prod_in;
   logic                 nb_ok_ff, nb_ok_in;
   logic                 div_start, div_done, div_phase_ff, div_phase_in;
   logic signed [QW-1:0] div_num, div_den, div_quot;

   hmb_div #(.W(QW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quot(div_quot)
   );

   logic accept;
   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   logic signed [IW-1:0] addr_s, absr, absc, f;
   logic signed [QW-1:0] res, lo, hi;
   // avg - m times the window weight: 17 by 6 bits
   logic signed [SAMPLE_BITS:0]      diff;
   logic signed [SAMPLE_BITS+DW+1:0] prod_small;
   assign addr_s = IW'({1'b0, req_address});
   assign hi = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
   assign lo = -hi - QW'(1);

   always_comb begin
      state_in = state_ff; rsp_valid_in = rsp_valid_ff; kind_in = kind_ff;
      pix_in = pix_ff; p_in = p_ff; t_in = t_ff; a_in = a_ff;
      r_in = r_ff; c_in = c_ff; i_in = i_ff; j_in = j_ff; m_in = m_ff;
      sum_in = sum_ff; cnt_in = cnt_ff; avg_in = avg_ff; prod_in = prod_ff;
      nb_ok_in = nb_ok_ff; div_phase_in = div_phase_ff;
      div_start = 1'b0; div_num = avg_ff; div_den = QW'(cnt_ff);
      rd_addr = p_ff[AW-1:0];
      wr_en = 1'b0; wr_mask_en = 1'b0; wr_addr = t_ff[AW-1:0];
      wr_base = req_base_value; wr_mask = req_mask_value;
      absr = r_ff < 0 ? -IW'(r_ff) : IW'(r_ff);
      absc = c_ff < 0 ? -IW'(c_ff) : IW'(c_ff);
      f = span - absr - absc;
      diff = div_quot[SAMPLE_BITS:0] - {m_ff[SAMPLE_BITS-1], m_ff};
      prod_small = diff * $signed(f[DW:0]);
      res = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            rd_addr = req_address[AW-1:0];
            if (accept) begin
               unique case (cmd_type'(req_command))
                  CMD_LOAD: begin
                     if (addr_s < npix) begin
                        wr_en = 1'b1; wr_mask_en = 1'b1;
                        wr_addr = req_address[AW-1:0];
                     end
                  end
                  CMD_RUN: begin
                     p_in = '0;
                     if (npix == 0) begin
                        rsp_valid_in = 1'b1; kind_in = KIND_DONE; pix_in = '0;
                     end else state_in = S_RDPIX;
                  end
                  CMD_READ: begin
                     kind_in = KIND_READ;
                     nb_ok_in = addr_s < npix;
                     state_in = S_READ;
                  end
                  default: ;
               endcase
            end
         end
         S_READ: begin
            pix_in = nb_ok_ff ? base_rd_ff : '0;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         S_RDPIX: begin
            rd_addr = p_ff[AW-1:0];
            state_in = S_PIX;
         end
         S_PIX: begin
            m_in = mask_rd_ff;
            r_in = -DW'(dist_eff); c_in = -DW'(dist_eff);
            state_in = (mask_rd_ff == 0) ? S_NEXT : S_TGT;
         end
         S_TGT: begin
            // target index; read its mask
            t_in = p_ff + IW'(r_ff) * side + IW'(c_ff);
            rd_addr = t_in[AW-1:0];
            if (t_in < 0 || t_in >= npix) state_in = S_QUO; // skip via advance
            else state_in = S_TCHK;
            nb_ok_in = !(t_in < 0 || t_in >= npix);
         end
         S_TCHK: begin
            if (mask_rd_ff != 0) begin
               nb_ok_in = 1'b0; state_in = S_QUO;
            end else begin
               i_in = 2'd0; j_in = 2'd0; sum_in = '0; cnt_in = '0;
               state_in = S_NB;
            end
         end
         S_NB: begin
            a_in = t_ff + (IW'(i_ff) - IW'(1)) * side + IW'(j_ff) - IW'(1);
            rd_addr = a_in[AW-1:0];
            state_in = S_NBACC;
         end
         S_NBACC: begin
            if (a_ff >= 0 && a_ff < npix && mask_rd_ff == 0) begin
               sum_in = sum_ff + (SAMPLE_BITS+4)'(base_rd_ff);
               cnt_in = cnt_ff + 4'd1;
            end
            if (j_ff == 2'd2) begin
               j_in = 2'd0;
               if (i_ff == 2'd2) state_in = S_AVG;
               else begin i_in = i_ff + 2'd1; state_in = S_NB; end
            end else begin
               j_in = j_ff + 2'd1; state_in = S_NB;
            end
         end
         S_AVG: begin
            if (cnt_ff == 0) begin
               nb_ok_in = 1'b0; state_in = S_QUO;
            end else begin
               div_start = 1'b1; div_num = QW'(sum_ff); div_den = QW'(cnt_ff);
               div_phase_in = 1'b0; state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (!div_phase_ff && div_done) begin
               avg_in = div_quot;
               prod_in = QW'(prod_small);
               div_phase_in = 1'b1;
            end else if (div_phase_ff) begin
               div_start = 1'b1; div_num = prod_ff; div_den = QW'(span);
               state_in = S_QUO;
            end
         end
         S_QUO: begin
            // wait for the quotient when a target is live, then step the window
            if (!nb_ok_ff || div_done) begin
               if (nb_ok_ff) begin
                  res = avg_ff - div_quot;
                  if (res > hi) res = hi;
                  if (res < lo) res = lo;
                  wr_en = 1'b1; wr_addr = t_ff[AW-1:0];
                  wr_base = res[SAMPLE_BITS-1:0];
               end
               nb_ok_in = 1'b0;
               if (IW'(c_ff) == dist_eff) begin
                  c_in = -DW'(dist_eff);
                  if (IW'(r_ff) == dist_eff) state_in = S_NEXT;
                  else begin r_in = r_ff + DW'(1); state_in = S_TGT; end
               end else begin
                  c_in = c_ff + DW'(1); state_in = S_TGT;
               end
            end
         end
         S_NEXT: begin
            // a masked pixel takes its mask once its window is done
            if (m_ff != 0) begin
               wr_en = 1'b1; wr_addr = p_ff[AW-1:0]; wr_base = m_ff;
            end
            if (p_ff + IW'(1) >= npix) begin
               rsp_valid_in = 1'b1; kind_in = KIND_DONE; pix_in = '0;
               state_in = S_IDLE;
            end else begin
               p_in = p_ff + IW'(1); state_in = S_RDPIX;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0; nb_ok_ff <= 1'b0;
         div_phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in; rsp_valid_ff <= rsp_valid_in; nb_ok_ff <= nb_ok_in;
         div_phase_ff <= div_phase_in;
      end
      kind_ff <= kind_in; pix_ff <= pix_in; p_ff <= p_in; t_ff <= t_in;
      a_ff <= a_in; r_ff <= r_in; c_ff <= c_in; i_ff <= i_in; j_ff <= j_in;
      m_ff <= m_in; sum_ff <= sum_in; cnt_ff <= cnt_in; avg_ff <= avg_in;
      prod_ff <= prod_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_pixel_value = pix_ff;
endmodule

// ===== rtl/core/hmb_div.sv =====
// restoring signed divider, one quotient bit per cycle, truncates toward zero
// depends on hmb_pkg
module hmb_div import hmb_pkg::*; #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [W-1:0] num,
   input  logic signed [W-1:0] den,
   output logic                done,
   output logic signed [W-1:0] quot
);
   localparam int CW = $clog2(W + 1);
   logic [W-1:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic         neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (start) begin
         q_in = num[W-1] ? -num : num;
         d_in = den[W-1] ? -den : den;
         r_in = '0;
         neg_in = num[W-1] ^ den[W-1];
         busy_in = 1'b1;
         cnt_in = CW'(W);
      end else if (busy_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -q_ff : q_ff;
endmodule
